/* rtl/sab_pkg.sv */
package sab_pkg;

  // pool and stack sizes
  localparam int SLOT_COUNT  = 256;
  localparam int STACK_DEPTH = 256;

  // field widths
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int PTR_W    = $clog2(SLOT_COUNT + 1);
  localparam int TOP_W    = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW   = $clog2(STACK_DEPTH);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

endpackage

/* rtl/sab_if.sv */
interface sab_in_if;
  import sab_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot_in;

  modport source (output valid, output req_type, output slot_in, input ready);
  modport sink   (input valid, input req_type, input slot_in, output ready);
endinterface

interface sab_out_if;
  import sab_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_out;
  logic [STATUS_W-1:0] status;
  logic [PTR_W-1:0]    high_water;

  modport source (output valid, output slot_out, output status, output high_water,
                  input ready);
  modport sink   (input valid, input slot_out, input status, input high_water,
                  output ready);
endinterface

/* rtl/slot_allocator_bump_recycle_core.sv */
// Slot allocator: grants and reclaims slot numbers from a pool of SLOT_COUNT
// slots, using a used bitmap, a bump pointer (high-water mark) and a stack
// of recycled slots. One request is worked at a time; in_req.ready is high
// only while the sequencer is idle. An allocate pops stack entries, each pop
// a read of the stack RAM and then a check of the candidate, until one is
// usable; when the stack runs dry it takes the slot at the bump pointer. A
// free clears the slot's used bit and pushes it on the stack if it has room,
// or, when it frees the slot just below the mark, lowers the mark, which then
// walks down past further free slots, one bitmap probe per cycle. A result
// sits in an output register, so the next request is taken while the
// previous result waits.
module slot_allocator_bump_recycle_core (
  input  logic clk,
  input  logic rst_n,
  sab_in_if.sink    in_req,
  sab_out_if.source out_rsp
);
  import sab_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_CHECK,
    S_BUMP,
    S_FREE,
    S_LOWER,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [SLOT_COUNT-1:0] used_r;      // one flop per slot, cleared by reset
  logic [PTR_W-1:0]    bump_r;
  logic [TOP_W-1:0]    top_r;         // number of valid stack entries

  // request capture
  logic                req_r;
  logic [SLOT_W-1:0]   slot_r;

  // result hold while the sequencer runs
  logic [SLOT_W-1:0]   res_slot_r;
  status_t             res_status_r;

  // output register
  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r;
  status_t             out_status_r;
  logic [PTR_W-1:0]    out_hw_r;

  // recycle stack RAM
  logic [SLOT_W-1:0]   stack_mem [STACK_DEPTH];
  logic [SLOT_W-1:0]   rd_data_r;
  logic                rd_en;
  logic                wr_en;
  logic [TOP_W-1:0]    top_m1;
  logic [PTR_W-1:0]    bump_m1;
  logic [PTR_W-1:0]    slot_p1;
  logic                cand_ok;
  logic                slot_in_range;
  logic                free_at_mark;
  logic                load_out;

  assign top_m1        = top_r - 1'b1;
  assign bump_m1       = bump_r - 1'b1;
  assign slot_p1       = PTR_W'(slot_r) + 1'b1;
  assign slot_in_range = PTR_W'(slot_r) < PTR_W'(SLOT_COUNT);
  assign free_at_mark  = (slot_p1 == bump_r);

  // popped candidate is usable if below the mark, in the pool, and not held
  assign cand_ok = (PTR_W'(rd_data_r) < bump_r) &&
                   (PTR_W'(rd_data_r) < PTR_W'(SLOT_COUNT)) &&
                   !used_r[rd_data_r];

  assign rd_en = (state_r == S_POP);
  assign wr_en = (state_r == S_FREE) && slot_in_range && !free_at_mark &&
                 (top_r < TOP_W'(STACK_DEPTH));

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  // stack RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[top_r[STK_AW-1:0]] <= slot_r;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[top_m1[STK_AW-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      bump_r      <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            req_r  <= in_req.req_type;
            slot_r <= in_req.slot_in;
            if (in_req.req_type == REQ_ALLOC) begin
              state_r <= (top_r != '0) ? S_POP : S_BUMP;
            end else begin
              state_r <= S_FREE;
            end
          end
        end

        // RAM read issued this cycle at top-1
        S_POP: begin
          top_r   <= top_m1;
          state_r <= S_CHECK;
        end

        S_CHECK: begin
          if (cand_ok) begin
            used_r[rd_data_r] <= 1'b1;
            res_slot_r        <= rd_data_r;
            res_status_r      <= ST_DONE;
            state_r           <= S_DONE;
          end else if (top_r != '0) begin
            state_r <= S_POP;
          end else begin
            state_r <= S_BUMP;
          end
        end

        S_BUMP: begin
          if (bump_r < PTR_W'(SLOT_COUNT)) begin
            used_r[bump_r[SLOT_W-1:0]] <= 1'b1;
            res_slot_r                 <= bump_r[SLOT_W-1:0];
            res_status_r               <= ST_DONE;
            bump_r                     <= bump_r + 1'b1;
          end else begin
            res_slot_r   <= '0;
            res_status_r <= ST_FULL;
          end
          state_r <= S_DONE;
        end

        S_FREE: begin
          res_slot_r <= '0;
          if (slot_in_range) begin
            used_r[slot_r] <= 1'b0;
            if (free_at_mark) begin
              bump_r       <= bump_m1;
              res_status_r <= ST_DONE;
              state_r      <= S_LOWER;
            end else if (top_r < TOP_W'(STACK_DEPTH)) begin
              top_r        <= top_r + 1'b1;
              res_status_r <= ST_DONE;
              state_r      <= S_DONE;
            end else begin
              res_status_r <= ST_DROPPED;
              state_r      <= S_DONE;
            end
          end else begin
            res_status_r <= ST_DONE;
            state_r      <= S_DONE;
          end
        end

        // walk the mark down past trailing free slots
        S_LOWER: begin
          if ((bump_r != '0) && !used_r[bump_m1[SLOT_W-1:0]]) begin
            bump_r <= bump_m1;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_DONE: begin
          if (load_out) begin
            out_slot_r   <= res_slot_r;
            out_status_r <= res_status_r;
            out_hw_r     <= bump_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.slot_out   = out_slot_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.high_water = out_hw_r;

  // mark and stack depth stay within range
  a_bump_range: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= PTR_W'(SLOT_COUNT))
    else $error("bump pointer beyond pool");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TOP_W'(STACK_DEPTH))
    else $error("stack top beyond depth");

  // pool full is only reported with an empty stack and the mark at the top
  a_full_cond: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && (res_status_r == ST_FULL) |->
      (bump_r == PTR_W'(SLOT_COUNT)) && (top_r == '0))
    else $error("pool full reported with slots left");

  // a granted slot is marked used
  a_grant_used: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && (req_r == REQ_ALLOC) && (res_status_r == ST_DONE) |=>
      used_r[$past(res_slot_r)])
    else $error("granted slot not marked used");

endmodule

/* test/tb_top.sv */
module tb_top;
  import sab_pkg::*;

  // One request as the stimulus side holds it.
  typedef struct {
    req_t              kind;
    logic [SLOT_W-1:0] slot;
  } slot_req_t;

  // One response as the block should report it.
  typedef struct {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic [PTR_W-1:0]  high_water;
  } pool_rsp_t;

  // Slowest legal request is an allocate that drains the whole stack,
  // so the drain wait at the end covers that.
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 22;

  logic clk;
  logic rst_n;

  sab_in_if  req_if ();
  sab_out_if rsp_if ();

  slot_allocator_bump_recycle_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if.sink),
    .out_rsp (rsp_if.source)
  );

  // Requests waiting to be driven, responses waiting to be seen.
  slot_req_t req_backlog[$];
  pool_rsp_t rsp_due[$];

  // Shadow copy of the pool: used bitmap, bump mark, recycle stack.
  bit                pool_used[SLOT_COUNT];
  int                pool_mark;
  int                pool_top;
  logic [SLOT_W-1:0] pool_stack[STACK_DEPTH];

  int  err_count;
  int  cycle_count;
  bit  steady;    // no idling on either side while set
  bit  took_req;  // transfer on the request side at the last rising edge

  // Works out the response to one request and updates the shadow pool.
  function automatic pool_rsp_t track_pool(slot_req_t r);
    pool_rsp_t rsp;
    int        cand;
    int        s;
    bit        found;
    rsp.slot   = '0;
    rsp.status = ST_DONE;
    found      = 1'b0;
    if (r.kind == REQ_ALLOC) begin
      // Pop until a candidate is below the mark and not held; stale
      // entries are thrown away on the way.
      while (!found && pool_top > 0) begin
        pool_top = pool_top - 1;
        cand     = int'(pool_stack[pool_top]);
        if (cand < pool_mark && !pool_used[cand]) begin
          found           = 1'b1;
          pool_used[cand] = 1'b1;
          rsp.slot        = cand[SLOT_W-1:0];
        end
      end
      if (!found) begin
        if (pool_mark < SLOT_COUNT) begin
          pool_used[pool_mark] = 1'b1;
          rsp.slot             = pool_mark[SLOT_W-1:0];
          pool_mark            = pool_mark + 1;
        end else begin
          rsp.status = ST_FULL;
        end
      end
    end else begin
      s = int'(r.slot);
      if (s < SLOT_COUNT) begin
        pool_used[s] = 1'b0;
        if (s + 1 == pool_mark) begin
          // Top slot freed: mark walks down past trailing free slots.
          pool_mark = pool_mark - 1;
          while (pool_mark > 0 && !pool_used[pool_mark-1])
            pool_mark = pool_mark - 1;
        end else if (pool_top < STACK_DEPTH) begin
          pool_stack[pool_top] = r.slot;
          pool_top             = pool_top + 1;
        end else begin
          rsp.status = ST_DROPPED;
        end
      end
    end
    rsp.high_water = pool_mark[PTR_W-1:0];
    return rsp;
  endfunction

  task automatic queue_req(req_t kind, int slot);
    slot_req_t r;
    r.kind = kind;
    r.slot = slot[SLOT_W-1:0];
    req_backlog.push_back(r);
  endtask

  task automatic wait_quiet();
    while (req_backlog.size() != 0 || rsp_due.size() != 0)
      @(posedge clk);
  endtask

  // Clock: 10 time units.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Request side, sampled at the rising edge: a transfer feeds the
  // shadow pool and leaves its response in the due list.
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      rsp_due.push_back(track_pool(req_backlog[0]));
      void'(req_backlog.pop_front());
      took_req = 1'b1;
    end
  end

  // Request driver: valid holds until the transfer, then the next item
  // goes up unless this cycle is an idle one.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !took_req) begin
      req_if.valid <= 1'b1;
    end else if (req_backlog.size() != 0 &&
                 (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
      req_if.valid    <= 1'b1;
      req_if.req_type <= req_backlog[0].kind;
      req_if.slot_in  <= req_backlog[0].slot;
    end else begin
      req_if.valid <= 1'b0;
    end
    took_req = 1'b0;
  end

  // Response side back-pressure.
  always @(negedge clk) begin
    rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Response monitor: each transfer is checked against the oldest due entry.
  always @(posedge clk) begin
    pool_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (rsp_due.size() == 0) begin
        $error("response with none due: slot_out %0d status %0d high_water %0d",
               rsp_if.slot_out, rsp_if.status, rsp_if.high_water);
        err_count = err_count + 1;
      end else begin
        want = rsp_due.pop_front();
        if (rsp_if.slot_out !== want.slot) begin
          $error("slot_out mismatch: expected %0d, actual %0d", want.slot, rsp_if.slot_out);
          err_count = err_count + 1;
        end
        if (rsp_if.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp_if.status);
          err_count = err_count + 1;
        end
        if (rsp_if.high_water !== want.high_water) begin
          $error("high_water mismatch: expected %0d, actual %0d",
                 want.high_water, rsp_if.high_water);
          err_count = err_count + 1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int i;
    err_count       = 0;
    cycle_count     = 0;
    steady          = 1'b0;
    took_req        = 1'b0;
    pool_mark       = 0;
    pool_top        = 0;
    for (i = 0; i < SLOT_COUNT; i++)
      pool_used[i] = 1'b0;
    for (i = 0; i < STACK_DEPTH; i++)
      pool_stack[i] = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_ALLOC;
    req_if.slot_in  = '0;
    rsp_if.ready    = 1'b0;
    rst_n           = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bump grants, top free with walk-down, duplicate free,
    // stale entries (held, or at/above the mark), allocate carrying a
    // nonzero slot_in.
    for (i = 0; i < 4; i++)
      queue_req(REQ_ALLOC, 0);
    queue_req(REQ_FREE, 3);
    queue_req(REQ_FREE, 1);
    queue_req(REQ_FREE, 1);
    queue_req(REQ_ALLOC, 8'hFF);
    queue_req(REQ_ALLOC, 8'hA5);
    queue_req(REQ_FREE, 255);
    queue_req(REQ_FREE, 200);
    queue_req(REQ_ALLOC, 0);
    queue_req(REQ_FREE, 0);
    queue_req(REQ_FREE, 1);
    queue_req(REQ_FREE, 2);
    queue_req(REQ_FREE, 3);
    queue_req(REQ_ALLOC, 8'h5A);
    queue_req(REQ_ALLOC, 0);
    queue_req(REQ_FREE, 1);
    queue_req(REQ_FREE, 0);
    queue_req(REQ_ALLOC, 0);

    // Mixed traffic, with most frees aimed at slots 0 to 47.
    for (i = 0; i < 350; i++) begin
      if ($urandom_range(0, 99) < 60)
        queue_req(REQ_ALLOC, $urandom_range(0, 255));
      else if ($urandom_range(0, 99) < 80)
        queue_req(REQ_FREE, $urandom_range(0, 47));
      else
        queue_req(REQ_FREE, $urandom_range(0, 255));
    end

    // Sender holds off until every due response has arrived.
    wait_quiet();

    // Run the pool dry with no idling anywhere, then pile frees below the
    // top slot until the stack overflows and frees get dropped.
    steady = 1'b1;
    for (i = 0; i < 262; i++)
      queue_req(REQ_ALLOC, $urandom_range(0, 255));
    wait_quiet();
    steady = 1'b0;
    for (i = 0; i < 270; i++)
      queue_req(REQ_FREE, $urandom_range(0, 254));
    for (i = 0; i < 40; i++)
      queue_req(REQ_ALLOC, $urandom_range(0, 255));
    queue_req(REQ_FREE, 255);

    // Uniform noise over the whole slot range.
    for (i = 0; i < 500; i++) begin
      if ($urandom_range(0, 1) == 0)
        queue_req(REQ_ALLOC, $urandom_range(0, 255));
      else
        queue_req(REQ_FREE, $urandom_range(0, 255));
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && rsp_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
